// ===== rtl/mcpf_pkg.sv =====
package mcpf_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 4;
  localparam int DATA_W   = 64;
  localparam int ALLOC_W  = 4;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REF   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_UNREF = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_AGAIN   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EOF     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BROKEN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_PIPE = 3'd5;

  typedef struct packed {
    logic                found;
    logic [ALLOC_W-1:0]  idx;
  } alloc_res_t;

endpackage

// ===== rtl/mcpf_ram.sv =====
module mcpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mcpf_alloc.sv =====
module mcpf_alloc #(
  parameter int N     = 16,
  parameter int NSRCH = 16
) (
  input  logic [N-1:0]              in_use,
  output mcpf_pkg::alloc_res_t      res
);

  import mcpf_pkg::*;

  // lowest free pipe wins
  always_comb begin
    res = '0;
    for (int k = NSRCH - 1; k >= 0; k--) begin
      if (!in_use[k]) begin
        res.found = 1'b1;
        res.idx   = ALLOC_W'(k);
      end
    end
  end

endmodule

// ===== rtl/multi_channel_pipe_fifo.sv =====
// Pool of byte pipes: NUM_PIPES ring buffers of PIPE_BYTES bytes each.
// Command port: an item is taken when start is high and busy is low. It
// carries one operation (alloc, read, write, add or drop a reference) and
// its arguments on the in_ ports.
// Result port: out_valid is high for exactly one cycle with the result on the
// out_ ports; the receiver has no way to hold it off and must take it then.
// Per-pipe counters (head, fill, reader and writer refs) live in a small
// synchronous RAM that is read after the command is taken and written back
// once; the buffer bytes live in a single-port byte RAM, one byte a cycle.
// Alloc, ref, unref and reads and writes that move nothing give their result
// straight from the evaluation state; a read or write that moves bytes goes
// through the byte transfer state first. busy falls in the cycle the result
// is shown, so the next command may be taken alongside it.
// Reset clears the in-use flags and the per-pipe valid bits, so every pipe's
// counters read as zero until first written; no clearing pass is needed.
// Buffer bytes are only ever read after they were written.
module multi_channel_pipe_fifo #(
  parameter int NUM_PIPES      = 16,
  parameter int PIPE_BYTES     = 4096,
  parameter int BYTES_PER_ITEM = 8,
  parameter int REF_MAX        = 255
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [mcpf_pkg::FUNC_W-1:0]     in_func,
  input  logic [3:0]                      in_pipe_id,
  input  logic [mcpf_pkg::COUNT_W-1:0]    in_byte_count,
  input  logic [mcpf_pkg::DATA_W-1:0]     in_write_data,
  input  logic                            in_writer_end,
  output logic                            out_valid,
  output logic [mcpf_pkg::STATUS_W-1:0]   out_status,
  output logic [mcpf_pkg::COUNT_W-1:0]    out_bytes_done,
  output logic [mcpf_pkg::DATA_W-1:0]     out_read_data,
  output logic [mcpf_pkg::ALLOC_W-1:0]    out_alloc_id,
  output logic                            out_wake_pipe,
  output logic                            out_raise_sigpipe
);

  import mcpf_pkg::*;

  localparam int PID_W      = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int ADDR_PIPES = (NUM_PIPES < 16) ? NUM_PIPES : 16;
  localparam int HEAD_W     = $clog2(PIPE_BYTES);
  localparam int FILL_W     = $clog2(PIPE_BYTES + 1);
  localparam int SUM_W      = FILL_W + 1;
  localparam int REF_W      = $clog2(REF_MAX + 1);
  localparam int ENT_W      = HEAD_W + FILL_W + 2 * REF_W;
  localparam int SA_W       = $clog2(NUM_PIPES * PIPE_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_XFER = 2'd2;

  // control
  logic [1:0]            state_r, state_nxt;
  logic [NUM_PIPES-1:0]  in_use_r, in_use_nxt;
  logic [NUM_PIPES-1:0]  ent_vld_r, ent_vld_nxt;
  logic                  ov_r, ov_nxt;
  logic                  pend_r, pend_nxt;

  // captured command
  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [PID_W-1:0]      id_r, id_nxt;
  logic                  idok_r, idok_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DATA_W-1:0]     wdata_r, wdata_nxt;
  logic                  wend_r, wend_nxt;

  // byte transfer sequencer
  logic                  rd_op_r, rd_op_nxt;
  logic [COUNT_W-1:0]    n_r, n_nxt;
  logic [COUNT_W-1:0]    i_r, i_nxt;
  logic [2:0]            lane_r, lane_nxt;
  logic [HEAD_W-1:0]     pos_r, pos_nxt;
  logic [SA_W-1:0]       base_r, base_nxt;

  // result
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [COUNT_W-1:0]    done_r, done_nxt;
  logic [DATA_W-1:0]     rdata_r, rdata_nxt;
  logic [ALLOC_W-1:0]    aid_r, aid_nxt;
  logic                  wake_r, wake_nxt;
  logic                  sig_r, sig_nxt;

  // memories
  logic                  st_we;
  logic [PID_W-1:0]      st_addr;
  logic [ENT_W-1:0]      st_wdata, st_q;
  logic                  by_we;
  logic [SA_W-1:0]       by_addr;
  logic [7:0]            by_q;

  alloc_res_t            alloc_res;

  // entry decode
  logic [ENT_W-1:0]      ent;
  logic [HEAD_W-1:0]     head;
  logic [FILL_W-1:0]     fill;
  logic [REF_W-1:0]      rrefs, wrefs, rr_new, wr_new;
  logic [SUM_W-1:0]      tail_s, head_s;
  logic [HEAD_W-1:0]     tail, head_new;
  logic [FILL_W-1:0]     cnt_f, rd_n, space, wr_n;
  logic [SUM_W-1:0]      pos_inc;
  logic                  len_bad;

  mcpf_ram #(.WIDTH(ENT_W), .DEPTH(NUM_PIPES)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_q)
  );

  mcpf_ram #(.WIDTH(8), .DEPTH(NUM_PIPES * PIPE_BYTES)) u_byte_ram (
    .clk   (clk),
    .we    (by_we),
    .addr  (by_addr),
    .wdata (wdata_r[7:0]),
    .rdata (by_q)
  );

  mcpf_alloc #(.N(NUM_PIPES), .NSRCH(ADDR_PIPES)) u_alloc (
    .in_use (in_use_r),
    .res    (alloc_res)
  );

  // counters of an entry never written read as zero
  assign ent   = ent_vld_r[id_r] ? st_q : '0;
  assign wrefs = ent[REF_W-1:0];
  assign rrefs = ent[2*REF_W-1:REF_W];
  assign fill  = ent[2*REF_W +: FILL_W];
  assign head  = ent[2*REF_W+FILL_W +: HEAD_W];

  assign cnt_f   = FILL_W'(cnt_r);
  assign rd_n    = (cnt_f < fill) ? cnt_f : fill;
  assign space   = FILL_W'(PIPE_BYTES) - fill;
  assign wr_n    = (cnt_f < space) ? cnt_f : space;
  assign len_bad = (cnt_r == '0) || (32'(cnt_r) > BYTES_PER_ITEM);

  assign tail_s   = SUM_W'(head) + SUM_W'(fill);
  assign tail     = (tail_s >= SUM_W'(PIPE_BYTES)) ? HEAD_W'(tail_s - SUM_W'(PIPE_BYTES))
                                                   : HEAD_W'(tail_s);
  assign head_s   = SUM_W'(head) + SUM_W'(rd_n);
  assign head_new = (head_s >= SUM_W'(PIPE_BYTES)) ? HEAD_W'(head_s - SUM_W'(PIPE_BYTES))
                                                   : HEAD_W'(head_s);
  assign pos_inc  = SUM_W'(pos_r) + SUM_W'(1);

  assign by_addr  = base_r + SA_W'(pos_r);

  always_comb begin
    state_nxt   = state_r;
    in_use_nxt  = in_use_r;
    ent_vld_nxt = ent_vld_r;
    ov_nxt      = 1'b0;
    pend_nxt    = 1'b0;
    func_nxt    = func_r;
    id_nxt      = id_r;
    idok_nxt    = idok_r;
    cnt_nxt     = cnt_r;
    wdata_nxt   = wdata_r;
    wend_nxt    = wend_r;
    rd_op_nxt   = rd_op_r;
    n_nxt       = n_r;
    i_nxt       = i_r;
    lane_nxt    = lane_r;
    pos_nxt     = pos_r;
    base_nxt    = base_r;
    status_nxt  = status_r;
    done_nxt    = done_r;
    rdata_nxt   = rdata_r;
    aid_nxt     = aid_r;
    wake_nxt    = wake_r;
    sig_nxt     = sig_r;
    st_we       = 1'b0;
    st_addr     = id_r;
    st_wdata    = ent;
    by_we       = 1'b0;
    rr_new      = rrefs;
    wr_new      = wrefs;

    unique case (state_r)
      S_IDLE: begin
        st_addr = PID_W'(in_pipe_id);
        if (start) begin
          func_nxt   = in_func;
          id_nxt     = PID_W'(in_pipe_id);
          idok_nxt   = 32'(in_pipe_id) < NUM_PIPES;
          cnt_nxt    = in_byte_count;
          wdata_nxt  = in_write_data;
          wend_nxt   = in_writer_end;
          status_nxt = ST_OK;
          done_nxt   = '0;
          rdata_nxt  = '0;
          aid_nxt    = '0;
          wake_nxt   = 1'b0;
          sig_nxt    = 1'b0;
          state_nxt  = S_EVAL;
        end
      end

      S_EVAL: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        base_nxt  = SA_W'(id_r) * SA_W'(PIPE_BYTES);
        if (func_r == FUNC_ALLOC) begin
          if (alloc_res.found) begin
            st_addr  = PID_W'(alloc_res.idx);
            st_we    = 1'b1;
            st_wdata = {HEAD_W'(0), FILL_W'(0), REF_W'(1), REF_W'(1)};
            in_use_nxt[st_addr]  = 1'b1;
            ent_vld_nxt[st_addr] = 1'b1;
            aid_nxt  = alloc_res.idx;
          end else begin
            status_nxt = ST_NO_PIPE;
          end
        end else if (func_r > FUNC_UNREF || !idok_r) begin
          status_nxt = ST_BAD;
        end else if (func_r == FUNC_READ || func_r == FUNC_WRITE) begin
          if (len_bad) begin
            status_nxt = ST_BAD;
          end else if (func_r == FUNC_READ) begin
            if (fill == '0) begin
              status_nxt = (wrefs == '0) ? ST_EOF : ST_AGAIN;
            end else begin
              st_we    = 1'b1;
              st_wdata = {head_new, fill - rd_n, rrefs, wrefs};
              ent_vld_nxt[id_r] = 1'b1;
              done_nxt  = COUNT_W'(rd_n);
              wake_nxt  = 1'b1;
              rd_op_nxt = 1'b1;
              n_nxt     = COUNT_W'(rd_n);
              i_nxt     = '0;
              pos_nxt   = head;
              ov_nxt    = 1'b0;
              state_nxt = S_XFER;
            end
          end else begin
            if (rrefs == '0) begin
              status_nxt = ST_BROKEN;
              sig_nxt    = 1'b1;
            end else if (space == '0) begin
              status_nxt = ST_AGAIN;
            end else begin
              st_we    = 1'b1;
              st_wdata = {head, fill + wr_n, rrefs, wrefs};
              ent_vld_nxt[id_r] = 1'b1;
              done_nxt  = COUNT_W'(wr_n);
              wake_nxt  = 1'b1;
              rd_op_nxt = 1'b0;
              n_nxt     = COUNT_W'(wr_n);
              i_nxt     = '0;
              pos_nxt   = tail;
              ov_nxt    = 1'b0;
              state_nxt = S_XFER;
            end
          end
        end else if (func_r == FUNC_REF) begin
          if (wend_r) begin
            if (32'(wrefs) < REF_MAX) wr_new = wrefs + REF_W'(1);
          end else begin
            if (32'(rrefs) < REF_MAX) rr_new = rrefs + REF_W'(1);
          end
          st_we    = 1'b1;
          st_wdata = {head, fill, rr_new, wr_new};
          ent_vld_nxt[id_r] = 1'b1;
        end else begin
          if (wend_r) begin
            if (wrefs != '0) wr_new = wrefs - REF_W'(1);
          end else begin
            if (rrefs != '0) rr_new = rrefs - REF_W'(1);
          end
          st_we    = 1'b1;
          st_wdata = {head, fill, rr_new, wr_new};
          ent_vld_nxt[id_r] = 1'b1;
          if (rr_new == '0 && wr_new == '0) in_use_nxt[id_r] = 1'b0;
          wake_nxt = 1'b1;
        end
      end

      S_XFER: begin
        // one byte a cycle; read data lands in the cycle after its address
        if (pend_r) begin
          rdata_nxt[lane_r*8 +: 8] = by_q;
        end
        if (i_r != n_r) begin
          by_we    = !rd_op_r;
          pend_nxt = rd_op_r;
          lane_nxt = i_r[2:0];
          i_nxt    = i_r + COUNT_W'(1);
          pos_nxt  = (pos_inc == SUM_W'(PIPE_BYTES)) ? '0 : HEAD_W'(pos_inc);
          if (!rd_op_r) wdata_nxt = wdata_r >> 8;
        end else if (!pend_r) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_use_r  <= '0;
      ent_vld_r <= '0;
      ov_r      <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_use_r  <= in_use_nxt;
      ent_vld_r <= ent_vld_nxt;
      ov_r      <= ov_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    id_r     <= id_nxt;
    idok_r   <= idok_nxt;
    cnt_r    <= cnt_nxt;
    wdata_r  <= wdata_nxt;
    wend_r   <= wend_nxt;
    rd_op_r  <= rd_op_nxt;
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    lane_r   <= lane_nxt;
    pos_r    <= pos_nxt;
    base_r   <= base_nxt;
    status_r <= status_nxt;
    done_r   <= done_nxt;
    rdata_r  <= rdata_nxt;
    aid_r    <= aid_nxt;
    wake_r   <= wake_nxt;
    sig_r    <= sig_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = ov_r;
  assign out_status        = status_r;
  assign out_bytes_done    = done_r;
  assign out_read_data     = rdata_r;
  assign out_alloc_id      = aid_r;
  assign out_wake_pipe     = wake_r;
  assign out_raise_sigpipe = sig_r;

  // a result only follows work in flight
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a command in flight");

  // a taken command is held until its result
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command taken without going busy");

  a_sigpipe_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_raise_sigpipe) |-> (out_status == ST_BROKEN))
    else $error("sigpipe flag without broken pipe status");

  a_done_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bytes_done != '0) |-> (out_status == ST_OK && out_wake_pipe))
    else $error("bytes moved on a failed transfer");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

endmodule

// ===== tb/multi_channel_pipe_fifo_tb.sv =====
`timescale 1ns / 100ps

// Pool-of-pipes testbench: a scoreboard class keeps its own copy of the pipe
// state, predicts one result per command transfer and compares each out_valid
// cycle against the oldest prediction.
class pipe_pool_scoreboard;
  localparam int NPIPES = 16;
  localparam int PBYTES = 4096;
  localparam int RMAX   = 255;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  done;
    logic [63:0] rdata;
    logic [3:0]  aid;
    logic        wake;
    logic        sigp;
  } outcome_t;

  bit          busy_flag [NPIPES];
  int unsigned head      [NPIPES];
  int unsigned fill      [NPIPES];
  int unsigned rd_refs   [NPIPES];
  int unsigned wr_refs   [NPIPES];
  logic [7:0]  bytes     [NPIPES*PBYTES];
  outcome_t    pending[$];
  int          mismatches;

  function void note_command(logic [2:0] fn, logic [3:0] id, logic [3:0] cnt,
                             logic [63:0] wd, logic wend);
    outcome_t o;
    int unsigned n, pos;
    o = '{default: '0};
    if (fn == mcpf_pkg::FUNC_ALLOC) begin
      o.status = mcpf_pkg::ST_NO_PIPE;
      for (int i = 0; i < NPIPES; i++) begin
        if (!busy_flag[i]) begin
          busy_flag[i] = 1; head[i] = 0; fill[i] = 0;
          rd_refs[i] = 1; wr_refs[i] = 1;
          o.status = mcpf_pkg::ST_OK;
          o.aid = 4'(i);
          break;
        end
      end
    end else if (fn > mcpf_pkg::FUNC_UNREF) begin
      o.status = mcpf_pkg::ST_BAD;
    end else if (fn == mcpf_pkg::FUNC_READ || fn == mcpf_pkg::FUNC_WRITE) begin
      if (cnt == 0 || cnt > 8) begin
        o.status = mcpf_pkg::ST_BAD;
      end else if (fn == mcpf_pkg::FUNC_READ) begin
        if (fill[id] == 0) begin
          o.status = (wr_refs[id] == 0) ? mcpf_pkg::ST_EOF : mcpf_pkg::ST_AGAIN;
        end else begin
          n = (cnt < fill[id]) ? cnt : fill[id];
          for (int i = 0; i < n; i++)
            o.rdata[8*i +: 8] = bytes[id*PBYTES + (head[id] + i) % PBYTES];
          head[id] = (head[id] + n) % PBYTES;
          fill[id] -= n;
          o.done = 4'(n);
          o.wake = 1;
        end
      end else begin
        if (rd_refs[id] == 0) begin
          o.status = mcpf_pkg::ST_BROKEN;
          o.sigp = 1;
        end else if (fill[id] >= PBYTES) begin
          o.status = mcpf_pkg::ST_AGAIN;
        end else begin
          n = (cnt < PBYTES - fill[id]) ? cnt : PBYTES - fill[id];
          pos = head[id] + fill[id];
          for (int i = 0; i < n; i++)
            bytes[id*PBYTES + (pos + i) % PBYTES] = wd[8*i +: 8];
          fill[id] += n;
          o.done = 4'(n);
          o.wake = 1;
        end
      end
    end else if (fn == mcpf_pkg::FUNC_REF) begin
      if (wend) begin
        if (wr_refs[id] < RMAX) wr_refs[id]++;
      end else begin
        if (rd_refs[id] < RMAX) rd_refs[id]++;
      end
    end else begin
      if (wend) begin
        if (wr_refs[id] > 0) wr_refs[id]--;
      end else begin
        if (rd_refs[id] > 0) rd_refs[id]--;
      end
      if (rd_refs[id] == 0 && wr_refs[id] == 0) busy_flag[id] = 0;
      o.wake = 1;
    end
    pending.push_back(o);
  endfunction

  function void check_result(logic [2:0] st, logic [3:0] dn, logic [63:0] rd,
                             logic [3:0] ai, logic wk, logic sp);
    outcome_t exp, got;
    got.status = st;
    got.done   = dn;
    got.rdata  = rd;
    got.aid    = ai;
    got.wake   = wk;
    got.sigp   = sp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: status %0d", got.status);
      return;
    end
    exp = pending.pop_front();
    if (got.status !== exp.status || got.done !== exp.done || got.rdata !== exp.rdata ||
        got.aid !== exp.aid || got.wake !== exp.wake || got.sigp !== exp.sigp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp st%0d n%0d d%h id%0d w%0d s%0d got st%0d n%0d d%h id%0d w%0d s%0d",
                 exp.status, exp.done, exp.rdata, exp.aid, exp.wake, exp.sigp,
                 got.status, got.done, got.rdata, got.aid, got.wake, got.sigp);
    end
  endfunction
endclass

module multi_channel_pipe_fifo_tb;
  import mcpf_pkg::*;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                start = 0;
  logic                busy;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [3:0]          in_pipe_id = '0;
  logic [COUNT_W-1:0]  in_byte_count = '0;
  logic [DATA_W-1:0]   in_write_data = '0;
  logic                in_writer_end = 0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_bytes_done;
  logic [DATA_W-1:0]   out_read_data;
  logic [ALLOC_W-1:0]  out_alloc_id;
  logic                out_wake_pipe;
  logic                out_raise_sigpipe;

  pipe_pool_scoreboard pool_sb = new();
  int burst_left;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  multi_channel_pipe_fifo dut (.*);

  // Result side: the receiver cannot stall, so every strobe is checked
  // at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      pool_sb.check_result(out_status, out_bytes_done, out_read_data,
                           out_alloc_id, out_wake_pipe, out_raise_sigpipe);
    end
  end

  // One command transfer. Gaps come between bursts; start stays high across
  // back-to-back commands within a burst so it is never lowered and raised
  // in the same step.
  task automatic issue(logic [2:0] fn, logic [3:0] id, logic [3:0] cnt,
                       logic [63:0] wd, logic wend);
    if (burst_left == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start         <= 1;
    in_func       <= fn;
    in_pipe_id    <= id;
    in_byte_count <= cnt;
    in_write_data <= wd;
    in_writer_end <= wend;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer taken at this edge
    pool_sb.note_command(fn, id, cnt, wd, wend);
  endtask

  task automatic drain();
    start <= 0;
    burst_left = 0;
    while (pool_sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    #200000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [2:0] fn;
    int pick;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty pool behaviour, full pool, bad lengths, unknown codes,
    // end of file, broken pipe with SIGPIPE, saturation, free by unref.
    issue(FUNC_READ, 4'd0, 4'd1, '0, 0);           // unallocated pipe reads as end of file
    issue(FUNC_WRITE, 4'd15, 4'd8, '1, 0);         // no readers: broken pipe
    for (int i = 0; i < 16; i++) issue(FUNC_ALLOC, 4'($urandom), 4'd0, '0, 0);
    issue(FUNC_ALLOC, 4'd0, 4'd0, '0, 0);          // pool full
    issue(FUNC_READ, 4'd3, 4'd1, '0, 0);           // would block
    issue(FUNC_WRITE, 4'd3, 4'd0, '1, 0);          // bad length zero
    issue(FUNC_WRITE, 4'd3, 4'd15, '1, 1);         // bad length too long
    issue(FUNC_WRITE, 4'd3, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    issue(FUNC_READ, 4'd3, 4'd15, '0, 0);
    issue(FUNC_READ, 4'd3, 4'd8, '0, 1);           // full read of the eight bytes
    issue(3'd5, 4'd2, 4'd1, '0, 0);                // unknown codes
    issue(3'd7, 4'd2, 4'd1, '0, 1);
    for (int i = 0; i < 256; i++) issue(FUNC_REF, 4'd1, 4'd0, '0, 1);  // saturation
    issue(FUNC_UNREF, 4'd0, 4'd0, '0, 0);
    issue(FUNC_UNREF, 4'd0, 4'd0, '0, 0);          // already zero stays zero
    issue(FUNC_UNREF, 4'd0, 4'd0, '0, 1);          // frees pipe 0
    issue(FUNC_ALLOC, 4'd0, 4'd0, '0, 0);
    drain();
    // quiet pause with nothing outstanding
    repeat (20) @(posedge clk);

    // Random part: mostly writes and reads on live pipes, some ref traffic.
    for (int i = 0; i < 300; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      fn = FUNC_WRITE;
      else if (pick < 70) fn = FUNC_READ;
      else if (pick < 78) fn = FUNC_REF;
      else if (pick < 88) fn = FUNC_UNREF;
      else if (pick < 96) fn = FUNC_ALLOC;
      else                fn = 3'($urandom_range(5, 7));
      issue(fn, 4'($urandom), ($urandom_range(0, 9) == 0) ? 4'($urandom) :
            4'($urandom_range(1, 8)), rand64(), 1'($urandom));
      if (i == 150) begin
        drain();
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end
    end
    drain();
    repeat (20) @(posedge clk);

    if (pool_sb.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
